[sv/shortest_remaining_time_scheduler_core_macros.svh]
// Assertion macros for the scheduler checker.
// Expects clk and arst_n in the scope of use.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_CORE_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define SRTF_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication
`define SRTF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

[sv/srtf_pkg.sv]
// Shared types and constants for the SRTF scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

	localparam int SLOT_W  = 3;
	localparam int BURST_W = 16;
	localparam int RES_W   = 16;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 40;

	localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic dec;
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/srtf_cell.sv]
// One job slot of the scheduler chain: slot state plus one stage of the
// running-minimum scan. Depends on srtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srtf_cell #(
	parameter int IDX_W     = 3,
	parameter int TIME_BITS = 16,
	parameter int CELL_IDX  = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srtf_pkg::cell_ctl_t             ctl,
	input  logic [srtf_pkg::BURST_W-1:0]    load_burst,
	input  logic [TIME_BITS-1:0]            load_time,
	output logic                            occupied,
	input  logic                            in_valid,
	input  logic [IDX_W-1:0]                in_idx,
	input  logic [srtf_pkg::BURST_W-1:0]    in_rem,
	input  logic [srtf_pkg::BURST_W-1:0]    in_burst,
	input  logic [TIME_BITS-1:0]            in_arr,
	output logic                            out_valid,
	output logic [IDX_W-1:0]                out_idx,
	output logic [srtf_pkg::BURST_W-1:0]    out_rem,
	output logic [srtf_pkg::BURST_W-1:0]    out_burst,
	output logic [TIME_BITS-1:0]            out_arr
);
	import srtf_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                 occ_q;
	logic [BURST_W-1:0]   rem_q;
	logic [BURST_W-1:0]   burst_q;
	logic [TIME_BITS-1:0] arr_q;
	logic                 take;

	logic                 valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic [BURST_W-1:0]   mrem_q;
	logic [BURST_W-1:0]   mburst_q;
	logic [TIME_BITS-1:0] marr_q;

	// strict less-than keeps the lower slot on ties
	assign take = occ_q && (!in_valid || (rem_q < in_rem));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.load) begin
			occ_q <= 1'b1;
		end else if (ctl.dec && (rem_q == BURST_W'(1))) begin
			occ_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q   <= load_burst;
			burst_q <= load_burst;
			arr_q   <= load_time;
		end else if (ctl.dec) begin
			rem_q <= rem_q - BURST_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid || take;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= take ? MY_IDX  : in_idx;
		mrem_q   <= take ? rem_q   : in_rem;
		mburst_q <= take ? burst_q : in_burst;
		marr_q   <= take ? arr_q   : in_arr;
	end

	assign occupied  = occ_q;
	assign out_valid = valid_q;
	assign out_idx   = idx_q;
	assign out_rem   = mrem_q;
	assign out_burst = mburst_q;
	assign out_arr   = marr_q;

endmodule

`default_nettype wire

[sv/shortest_remaining_time_scheduler_core.sv]
// Shortest-remaining-time-first scheduler over MAX_JOBS job slots held in
// a chain of slot cells, one registered compare stage per cell. An arrival
// request loads its result registers on acceptance, then the output register
// from ST_RESULT; no new request is taken until the result is loaded. A tick
// request walks the minimum through the whole chain in ST_SCAN, then does
// the slot update in ST_UPDATE, the finish times in ST_FINISH and loads the
// output register in ST_RESULT before the next request is taken. A held
// output stalls ST_RESULT, so it delays the pending result and the next request.
// Depends on srtf_pkg and srtf_cell.
`timescale 1ns / 1ps
`default_nettype none

module shortest_remaining_time_scheduler_core #(
	parameter int MAX_JOBS  = 8,
	parameter int TIME_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [2:0] job_slot, [18:3] burst_length, [23:19] zero
	input  logic [srtf_pkg::IN_W-1:0]   s_tdata,
	// [0] command
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] busy_res, [3:1] running_job, [4] finished, [20:5] waiting_time,
	// [36:21] turnaround_time, [37] slot_error, [39:38] zero
	output logic [srtf_pkg::OUT_W-1:0]  m_tdata
);
	import srtf_pkg::*;

	localparam int IDX_W  = $clog2(MAX_JOBS);
	localparam int WIDE_W = (TIME_BITS > RES_W) ? TIME_BITS : RES_W;

	state_t state_q, state_nx;

	logic [SLOT_W-1:0]    job_slot;
	logic [BURST_W-1:0]   burst_length;
	cmd_t                 command;
	logic                 accept;

	logic [MAX_JOBS-1:0]  hit;
	logic [MAX_JOBS-1:0]  occ;
	logic                 slot_err;
	cell_ctl_t            ctl [MAX_JOBS];

	logic [MAX_JOBS:0]    ch_valid;
	logic [IDX_W-1:0]     ch_idx   [MAX_JOBS+1];
	logic [BURST_W-1:0]   ch_rem   [MAX_JOBS+1];
	logic [BURST_W-1:0]   ch_burst [MAX_JOBS+1];
	logic [TIME_BITS-1:0] ch_arr   [MAX_JOBS+1];

	logic [IDX_W-1:0]     cnt_q;
	logic                 scan_done;
	logic                 upd_en;
	logic                 res_load;

	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] time_nx;

	logic                 busy_q;
	logic [IDX_W-1:0]     run_q;
	logic                 fin_q;
	logic [TIME_BITS-1:0] t_q;
	logic [BURST_W-1:0]   bst_q;

	logic [WIDE_W-1:0]    tw;
	logic [WIDE_W-1:0]    bw;
	logic [WIDE_W-1:0]    diff;
	logic [RES_W-1:0]     tat;
	logic [RES_W-1:0]     wt;

	logic                 r_busy_q;
	logic [SLOT_W-1:0]    r_run_q;
	logic                 r_fin_q;
	logic [RES_W-1:0]     r_wt_q;
	logic [RES_W-1:0]     r_tat_q;
	logic                 r_err_q;

	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;
	logic                 out_free;

	assign job_slot     = s_tdata[SLOT_W-1:0];
	assign burst_length = s_tdata[SLOT_W +: BURST_W];
	assign command      = cmd_t'(s_tuser);
	assign accept       = s_tvalid && s_tready;

	// slot cells
	assign ch_valid[0] = 1'b0;
	assign ch_idx[0]   = '0;
	assign ch_rem[0]   = '0;
	assign ch_burst[0] = '0;
	assign ch_arr[0]   = '0;

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		assign hit[i]      = (int'(job_slot) == i);
		assign ctl[i].load = accept && (command == CMD_ARRIVE) && hit[i] && !occ[i]
			&& (burst_length != '0);
		assign ctl[i].dec  = upd_en && ch_valid[MAX_JOBS]
			&& (ch_idx[MAX_JOBS] == IDX_W'(i));

		srtf_cell #(
			.IDX_W     (IDX_W),
			.TIME_BITS (TIME_BITS),
			.CELL_IDX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.load_burst (burst_length),
			.load_time  (time_q),
			.occupied   (occ[i]),
			.in_valid   (ch_valid[i]),
			.in_idx     (ch_idx[i]),
			.in_rem     (ch_rem[i]),
			.in_burst   (ch_burst[i]),
			.in_arr     (ch_arr[i]),
			.out_valid  (ch_valid[i+1]),
			.out_idx    (ch_idx[i+1]),
			.out_rem    (ch_rem[i+1]),
			.out_burst  (ch_burst[i+1]),
			.out_arr    (ch_arr[i+1])
		);
	end

	// no matching slot or an occupied one
	assign slot_err = !(|hit) || |(hit & occ);

	// control
	assign scan_done = (cnt_q == IDX_W'(MAX_JOBS - 1));
	assign out_free  = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		upd_en   = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nx = (command == CMD_TICK) ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				upd_en   = 1'b1;
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				state_nx = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// time counter, saturating
	assign time_nx = (time_q == '1) ? time_q : time_q + TIME_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (upd_en) begin
			time_q <= time_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			busy_q <= ch_valid[MAX_JOBS];
			run_q  <= ch_idx[MAX_JOBS];
			fin_q  <= ch_valid[MAX_JOBS] && (ch_rem[MAX_JOBS] == BURST_W'(1));
			t_q    <= time_nx - ch_arr[MAX_JOBS];
			bst_q  <= ch_burst[MAX_JOBS];
		end
	end

	// finish times
	assign tw   = WIDE_W'(t_q);
	assign bw   = WIDE_W'(bst_q);
	assign diff = tw - bw;
	assign tat  = (tw > WIDE_W'(RES_MAX)) ? RES_MAX : tw[RES_W-1:0];
	assign wt   = (tw <= bw) ? '0
		: ((diff > WIDE_W'(RES_MAX)) ? RES_MAX : diff[RES_W-1:0]);

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_ARRIVE)) begin
			r_busy_q <= 1'b0;
			r_run_q  <= '0;
			r_fin_q  <= 1'b0;
			r_wt_q   <= '0;
			r_tat_q  <= '0;
			r_err_q  <= slot_err;
		end else if (state_q == ST_FINISH) begin
			r_busy_q <= busy_q;
			r_run_q  <= busy_q ? SLOT_W'(run_q) : '0;
			r_fin_q  <= fin_q;
			r_wt_q   <= fin_q ? wt : '0;
			r_tat_q  <= fin_q ? tat : '0;
			r_err_q  <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_data_q <= {2'b00, r_err_q, r_tat_q, r_wt_q, r_fin_q, r_run_q, r_busy_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

[sv/srtf_checker.sv]
// Port-level checks for the SRTF scheduler, bound to the top level.
// Depends on srtf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "shortest_remaining_time_scheduler_core_macros.svh"

module srtf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [srtf_pkg::OUT_W-1:0] m_tdata
);
	import srtf_pkg::*;

	`SRTF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`SRTF_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
	`SRTF_ASSERT_IMPL(a_fin_busy, m_tvalid && m_tdata[4], m_tdata[0])
	`SRTF_ASSERT_IMPL(a_wait_le_tat, m_tvalid && m_tdata[4], m_tdata[20:5] <= m_tdata[36:21])
	`SRTF_ASSERT_IMPL(a_err_idle, m_tvalid && m_tdata[37], !m_tdata[0] && !m_tdata[4])

endmodule

bind shortest_remaining_time_scheduler_core srtf_checker u_srtf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[bench/shortest_remaining_time_scheduler_core_test.sv]
// Self-checking bench for shortest_remaining_time_scheduler_core: directed and random
// arrive/tick requests, predicted scheduling results compared field by field.
// Depends on srtf_pkg, the core and its slot cells.
`timescale 1ns / 1ps

module shortest_remaining_time_scheduler_core_test;

	import srtf_pkg::*;

	localparam int SLOTS = 8;
	localparam logic [BURST_W-1:0] TIME_TOP = '1;
	localparam int CYCLE_LIMIT = 400_000;

	typedef struct {
		cmd_t                cmd;
		logic [SLOT_W-1:0]   slot;
		logic [BURST_W-1:0]  burst;
		int                  idle_odds;
	} sched_cmd_t;

	typedef struct packed {
		logic [1:0]          pad;
		logic                slot_error;
		logic [RES_W-1:0]    turnaround;
		logic [RES_W-1:0]    waiting;
		logic                finished;
		logic [SLOT_W-1:0]   runner;
		logic                busy;
	} sched_report_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	sched_cmd_t      sched_cmds[$];
	sched_report_t   due_reports[$];

	// predicted scheduler state
	logic [BURST_W-1:0]  left_ticks [SLOTS];
	logic [BURST_W-1:0]  job_len [SLOTS];
	logic [BURST_W-1:0]  job_start [SLOTS];
	logic                job_live [SLOTS] = '{default: 1'b0};
	logic [BURST_W-1:0]  clock_now = '0;

	bit   req_taken = 0;
	bit   stall_done = 0;
	int   traffic_odds = 4;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   stall_left = 0;
	int   results_checked = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	shortest_remaining_time_scheduler_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic sched_report_t srtf_step(cmd_t cmd, logic [SLOT_W-1:0] slot,
			logic [BURST_W-1:0] burst);
		sched_report_t r;
		int pick;
		logic [BURST_W-1:0] span;
		r = '0;
		if (cmd == CMD_ARRIVE) begin
			if (job_live[slot]) begin
				r.slot_error = 1'b1;
			end else if (burst != 0) begin
				job_live[slot] = 1'b1;
				left_ticks[slot] = burst;
				job_len[slot] = burst;
				job_start[slot] = clock_now;
			end
		end else begin
			pick = -1;
			for (int i = 0; i < SLOTS; i++)
				if (job_live[i] && (pick < 0 || left_ticks[i] < left_ticks[pick]))
					pick = i;
			if (clock_now != TIME_TOP)
				clock_now++;
			if (pick >= 0) begin
				r.busy = 1'b1;
				r.runner = SLOT_W'(pick);
				left_ticks[pick]--;
				if (left_ticks[pick] == 0) begin
					span = clock_now - job_start[pick];
					r.finished = 1'b1;
					r.turnaround = span;
					r.waiting = (span > job_len[pick]) ? span - job_len[pick] : '0;
					job_live[pick] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_arrive(int slot, int burst, int odds);
		sched_cmd_t c;
		c.cmd = CMD_ARRIVE;
		c.slot = SLOT_W'(slot);
		c.burst = BURST_W'(burst);
		c.idle_odds = odds;
		sched_cmds.push_back(c);
	endtask

	task automatic queue_tick(int odds);
		sched_cmd_t c;
		c.cmd = CMD_TICK;
		c.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		c.burst = BURST_W'($urandom);
		c.idle_odds = odds;
		sched_cmds.push_back(c);
	endtask

	task automatic drain_all();
		while (sched_cmds.size() != 0 || s_tvalid || due_reports.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		sched_cmd_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (sched_cmds.size() != 0) begin
				nxt = sched_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.cmd;
				s_tdata <= {5'b0, nxt.burst, nxt.slot};
				traffic_odds = nxt.idle_odds;
				if (traffic_odds != 0 && $urandom_range(1, traffic_odds) == 1)
					send_gap = $urandom_range(1, 16);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side ready, with one long hold-off to back the core up
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!stall_done && results_checked >= 300) begin
				stall_left = 400;
				stall_done = 1;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (traffic_odds != 0 && $urandom_range(1, traffic_odds) == 1)
					recv_gap = $urandom_range(1, 16);
			end
		end
	end

	// request capture and result check
	always @(posedge clk) begin
		sched_report_t want, got;
		req_taken = arst_n && s_tvalid && s_tready;
		if (req_taken)
			due_reports.push_back(srtf_step(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[18:3]));
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			got = sched_report_t'(m_tdata);
			if (due_reports.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = due_reports.pop_front();
				check_field("busy_res", want.busy, got.busy);
				check_field("running_job", want.runner, got.runner);
				check_field("finished", want.finished, got.finished);
				check_field("waiting_time", want.waiting, got.waiting);
				check_field("turnaround_time", want.turnaround, got.turnaround);
				check_field("slot_error", want.slot_error, got.slot_error);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("shortest_remaining_time_scheduler_core regression: fail");
			$finish;
		end
	end

	initial begin
		int odds;
		int pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle tick, busy slot, zero burst, tie, preemption, extremes
		queue_tick(4);
		queue_arrive(0, 3, 4);
		queue_arrive(0, 5, 4);
		queue_arrive(1, 0, 4);
		queue_tick(4);
		queue_arrive(2, 2, 4);
		queue_tick(4);
		queue_arrive(5, 1, 4);
		queue_tick(4);
		queue_tick(4);
		queue_tick(4);
		queue_tick(4);
		queue_arrive(7, 16'hFFFF, 4);
		queue_arrive(7, 1, 4);
		queue_arrive(6, 1, 4);
		queue_arrive(3, 2, 4);
		queue_tick(4);
		queue_tick(4);
		queue_tick(4);
		queue_tick(4);
		queue_arrive(1, 1, 4);
		queue_tick(4);
		drain_all();

		// random traffic, idling rate changes every 200 requests
		for (int seg = 0; seg < 8; seg++) begin
			odds = (seg % 4 == 3) ? 0 : (1 << $urandom_range(1, 4));
			for (int n = 0; n < 200; n++) begin
				if ($urandom_range(0, 99) < 18) begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						queue_arrive($urandom_range(0, SLOTS - 1), 0, odds);
					else if (pick < 88)
						queue_arrive($urandom_range(0, SLOTS - 1), $urandom_range(1, 4), odds);
					else
						queue_arrive($urandom_range(0, SLOTS - 1), $urandom_range(5, 32), odds);
				end else begin
					queue_tick(odds);
				end
			end
		end
		drain_all();

		// closing stretch, no idling from here on
		for (int n = 0; n < 130; n++) begin
			if ($urandom_range(0, 9) == 0)
				queue_arrive($urandom_range(0, SLOTS - 1), $urandom_range(1, 64), 0);
			else
				queue_tick(0);
		end

		drain_all();
		repeat (3 * (SLOTS + 4)) @(posedge clk);
		if (fail_count == 0)
			$display("shortest_remaining_time_scheduler_core regression: pass");
		else
			$display("shortest_remaining_time_scheduler_core regression: fail");
		$finish;
	end

endmodule
